### sv/sorted_min_priority_queue_assert.svh
// Assertion macros shared by the sorted minimum-priority queue modules.
`ifndef SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SMPQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smpq assertion failed");

// Next-cycle implication, disabled during reset.
`define SMPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smpq assertion failed");

`endif

### sv/smpq_pkg.sv
// Types and constants of the sorted minimum-priority queue.
package smpq_pkg;

   localparam int DEPTH      = 16;
   localparam int PRIO_BITS  = 16;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef logic signed [PRIO_BITS-1:0] prio_type;
   typedef logic [COUNT_BITS-1:0]       count_type;

   typedef struct packed {
      logic     opcode;
      prio_type priority_in;
   } req_type;

   typedef struct packed {
      logic      ok;
      prio_type  priority_out;
      count_type count_out;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic load;
      logic commit;
   } cmd_type;

endpackage

### sv/smpq_ctrl.sv
// Controller state machine of the sorted minimum-priority queue.
`include "sorted_min_priority_queue_assert.svh"

module smpq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output smpq_pkg::cmd_type cmd
);

   smpq_pkg::state_type state_ff;
   smpq_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smpq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.commit   = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         smpq_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = smpq_pkg::ST_EXEC;
            end
         end
         smpq_pkg::ST_EXEC: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = smpq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smpq_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != smpq_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `SMPQ_ASSERT_NEXT(a_load_to_exec, clock, reset, req_valid && !req_stall,
                     state_ff == smpq_pkg::ST_EXEC)
   `SMPQ_ASSERT_NEXT(a_commit_shows, clock, reset, cmd.commit, rsp_valid)
   `SMPQ_ASSERT_NEXT(a_exec_waits, clock, reset,
                     state_ff == smpq_pkg::ST_EXEC && rsp_valid && rsp_stall,
                     state_ff == smpq_pkg::ST_EXEC)

endmodule

### sv/smpq_dp.sv
// Datapath of the sorted minimum-priority queue: sorted entry array and result register.
`include "sorted_min_priority_queue_assert.svh"

module smpq_dp (
   input  logic              clock,
   input  logic              reset,
   input  smpq_pkg::cmd_type cmd,
   input  smpq_pkg::req_type req_item,
   output smpq_pkg::rsp_type rsp_item
);

   smpq_pkg::req_type   req_ff;
   smpq_pkg::rsp_type   rsp_ff;
   smpq_pkg::rsp_type   rsp_in;
   smpq_pkg::count_type count_ff;
   smpq_pkg::count_type count_in;
   smpq_pkg::prio_type  entries_ff [smpq_pkg::DEPTH];
   smpq_pkg::prio_type  entries_in [smpq_pkg::DEPTH];
   logic [smpq_pkg::DEPTH-1:0] after;
   logic                is_insert;
   logic                ok_now;
   logic                write_en;

   assign is_insert = (req_ff.opcode == smpq_pkg::OP_INSERT);
   assign ok_now    = is_insert ? (count_ff != smpq_pkg::COUNT_BITS'(smpq_pkg::DEPTH))
                                : (count_ff != '0);
   assign write_en  = cmd.commit && ok_now;

   // An entry lies at or after the insert point when it is unused or strictly greater.
   always_comb begin
      for (int i = 0; i < smpq_pkg::DEPTH; i++) begin
         after[i] = (smpq_pkg::COUNT_BITS'(i) >= count_ff) ||
                    (entries_ff[i] > req_ff.priority_in);
      end
   end

   always_comb begin
      for (int i = 0; i < smpq_pkg::DEPTH; i++) begin
         if (is_insert) begin
            if (!after[i]) begin
               entries_in[i] = entries_ff[i];
            end else if (i > 0 && after[(i > 0) ? i - 1 : 0]) begin
               entries_in[i] = entries_ff[(i > 0) ? i - 1 : 0];
            end else begin
               entries_in[i] = req_ff.priority_in;
            end
         end else begin
            entries_in[i] = entries_ff[(i < smpq_pkg::DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      if (!ok_now) begin
         count_in = count_ff;
      end else if (is_insert) begin
         count_in = count_ff + 1'b1;
      end else begin
         count_in = count_ff - 1'b1;
      end
      rsp_in.ok           = ok_now;
      rsp_in.priority_out = (!is_insert && ok_now) ? entries_ff[0] : '0;
      rsp_in.count_out    = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (write_en) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
      if (write_en) begin
         for (int i = 0; i < smpq_pkg::DEPTH; i++) begin
            entries_ff[i] <= entries_in[i];
         end
      end
   end

   assign rsp_item = rsp_ff;

   `SMPQ_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1,
                     count_ff <= smpq_pkg::COUNT_BITS'(smpq_pkg::DEPTH))
   `SMPQ_ASSERT_NEXT(a_reject_holds, clock, reset, cmd.commit && !ok_now,
                     $stable(count_ff))
   `SMPQ_ASSERT_NEXT(a_remove_dec, clock, reset,
                     cmd.commit && !is_insert && count_ff != '0,
                     count_ff == $past(count_ff) - 1'b1)

endmodule

### sv/sorted_min_priority_queue.sv
// Top level of the sorted minimum-priority queue.
//
//   Channel   Ports                          Carries
//   request   req_valid req_stall req_item   opcode, priority_in
//   response  rsp_valid rsp_stall rsp_item   ok, priority_out, count_out
//
// Each item passes through ST_IDLE, which captures the request, then ST_EXEC,
// which does the parallel compare and shift across all entries of the array.
// The next request is taken while a finished response waits to be taken.
// A stalled response holds the array update until the response register frees.
// Reset empties the queue; entry contents stay undefined.
module sorted_min_priority_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  smpq_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output smpq_pkg::rsp_type rsp_item
);

   smpq_pkg::cmd_type cmd;

   smpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   smpq_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

endmodule
